FILE: rtl/pbd_pkg.sv
// Shared types and constants for the premultiplied box downscaler.
package pbd_pkg;

   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int BLOCK_W     = 5;
   localparam int SUB_W       = 4;
   localparam int CHAN_W      = 8;
   localparam int CSUM_W      = 24;
   localparam int ASUM_W      = 16;
   localparam int POS_W       = 11;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 56;

   // divider: numerator 2*S+A, divisor 2*A shifted left by one less than the quotient width
   localparam int QUO_W = 9;
   localparam int NUM_W = CSUM_W + 2;
   localparam int DEN_W = ASUM_W + 1;
   localparam int DSH_W = DEN_W + QUO_W - 1;
   localparam int LANES = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_SIZE = 1'b1;

   localparam logic [CSR_DATA_W-1:0] SRC_WIDTH_RESET  = 12'd128;
   localparam logic [BLOCK_W-1:0]    BLOCK_SIZE_RESET = 5'd2;

   typedef struct packed {
      logic [CSUM_W-1:0] red;
      logic [CSUM_W-1:0] green;
      logic [CSUM_W-1:0] blue;
      logic [ASUM_W-1:0] alpha;
   } sums_type;

endpackage

FILE: rtl/premultiplied_box_downscale.sv
// Premultiplied-alpha box downscaler: column sums in memory, serial divider.
//
// Reduces each block_size x block_size tile of a square straight-alpha RGBA
// image (raster order, one pixel per beat) to one pixel: colour is the
// alpha-weighted mean rounded half up, alpha the tile mean rounded half up,
// all zero where the tile alpha sum is zero. Per-column partial sums live in
// one synchronous memory of MAX_SRC_WIDTH words, read, updated and written
// back for each pixel. A pixel goes through accept, memory read, and
// accumulate and write back; a pixel that closes a tile then goes through
// the radix-2 divider (one quotient bit per cycle, four lanes in
// parallel) and a load of the output register once that is free. Pixels
// outside the last full tile are only accepted. The memory needs no
// clearing: a tile's first pixel starts its sums from zero. Any csr write
// restarts the frame; write only while the block is idle.
module premultiplied_box_downscale #(
   parameter int MAX_SRC_WIDTH = 2048,
   parameter int MAX_BLOCK     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // in_red, in_green, in_blue, in_alpha
   input  logic [pbd_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_red, out_green, out_blue, out_alpha, out_col, out_row, zero fill
   output logic [pbd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [pbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_SRC_WIDTH);
   localparam int CW = AW + 1;
   localparam int EW = (CW > pbd_pkg::CSR_DATA_W) ? CW : pbd_pkg::CSR_DATA_W;
   localparam int DW = $bits(pbd_pkg::sums_type);
   localparam int LW = pbd_pkg::LANES;
   localparam int NW = pbd_pkg::NUM_W;
   localparam int SW = pbd_pkg::DSH_W;
   localparam int QW = pbd_pkg::QUO_W;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_DIV, S_HOLD} state_type;

   // configuration
   logic [pbd_pkg::CSR_DATA_W-1:0] width_ff;
   logic [pbd_pkg::BLOCK_W-1:0]    block_ff;
   logic [CW-1:0]                  w_eff;
   logic [pbd_pkg::BLOCK_W-1:0]    b_eff;
   logic [EW-1:0]                  width_ext;

   // position counters
   logic [CW-1:0]              col_ff, row_ff, tbc_ff, tbr_ff;
   logic [AW-1:0]              tcol_ff, trow_ff;
   logic [pbd_pkg::SUB_W-1:0]  subc_ff, subr_ff;

   // item registers
   state_type                  state_ff;
   logic [pbd_pkg::CHAN_W-1:0] pr_ff, pg_ff, pb_ff, pa_ff;
   logic                       first_ff, emit_ff, last_ff;
   logic [AW-1:0]              icol_ff, irow_ff;

   // memory
   logic [DW-1:0]              mem [MAX_SRC_WIDTH];
   pbd_pkg::sums_type          rd_ff, base, upd;

   // divider
   logic [NW-1:0]  rem_ff [LW];
   logic [SW-1:0]  dsh_ff [LW];
   logic [QW-1:0]  quo_ff [LW];
   logic [3:0]     step_ff;
   logic           zero_ff;

   // output register
   logic                              rsp_valid_ff;
   logic [pbd_pkg::RSP_DATA_W-1:0]    rsp_data_ff;
   logic                              rsp_last_ff;
   logic                              rsp_zero_ff;

   logic                       accept, advance;
   logic [CW:0]                b_ext, tbc_end, tbr_end, tbc_end2, tbr_end2, w_ext;
   logic                       in_range, is_first, is_emit, is_last;
   logic [pbd_pkg::BLOCK_W-1:0] b_m1;
   logic [pbd_pkg::BLOCK_W-1:0] subc_p1, subr_p1;
   logic [9:0]                 area2;
   logic [pbd_pkg::CHAN_W-1:0] q_clamp [LW];
   logic [pbd_pkg::RSP_DATA_W-1:0] rsp_next;

   // clamp the registers into their usable ranges
   always_comb begin
      width_ext = EW'(width_ff);
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (width_ext > EW'(MAX_SRC_WIDTH)) begin
         w_eff = CW'(MAX_SRC_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (block_ff == '0) begin
         b_eff = pbd_pkg::BLOCK_W'(1);
      end else if (block_ff > pbd_pkg::BLOCK_W'(MAX_BLOCK)) begin
         b_eff = pbd_pkg::BLOCK_W'(MAX_BLOCK);
      end else begin
         b_eff = block_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // tile tests by tile base position, no division needed
   always_comb begin
      b_ext    = (CW+1)'(b_eff);
      w_ext    = (CW+1)'(w_eff);
      tbc_end  = (CW+1)'(tbc_ff) + b_ext;
      tbr_end  = (CW+1)'(tbr_ff) + b_ext;
      tbc_end2 = tbc_end + b_ext;
      tbr_end2 = tbr_end + b_ext;
      b_m1     = b_eff - pbd_pkg::BLOCK_W'(1);
      subc_p1  = pbd_pkg::BLOCK_W'(subc_ff) + pbd_pkg::BLOCK_W'(1);
      subr_p1  = pbd_pkg::BLOCK_W'(subr_ff) + pbd_pkg::BLOCK_W'(1);
      in_range = (tbc_end <= w_ext) && (tbr_end <= w_ext);
      is_first = (subc_ff == '0) && (subr_ff == '0);
      is_emit  = (pbd_pkg::BLOCK_W'(subc_ff) == b_m1)
              && (pbd_pkg::BLOCK_W'(subr_ff) == b_m1);
      is_last  = (tbc_end2 > w_ext) && (tbr_end2 > w_ext);
      area2    = 10'(b_eff) * 10'(b_eff) * 10'd2;
   end

   // configuration and source position
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= pbd_pkg::SRC_WIDTH_RESET;
         block_ff <= pbd_pkg::BLOCK_SIZE_RESET;
         col_ff <= '0; row_ff <= '0; tbc_ff <= '0; tbr_ff <= '0;
         tcol_ff <= '0; trow_ff <= '0; subc_ff <= '0; subr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pbd_pkg::REG_SRC_WIDTH:  width_ff <= csr_wdata;
            pbd_pkg::REG_BLOCK_SIZE: block_ff <= pbd_pkg::BLOCK_W'(csr_wdata);
            default: ;
         endcase
         col_ff <= '0; row_ff <= '0; tbc_ff <= '0; tbr_ff <= '0;
         tcol_ff <= '0; trow_ff <= '0; subc_ff <= '0; subr_ff <= '0;
      end else if (accept) begin
         if ((CW+1)'(col_ff) + (CW+1)'(1) >= w_ext) begin
            col_ff <= '0; subc_ff <= '0; tbc_ff <= '0; tcol_ff <= '0;
            if ((CW+1)'(row_ff) + (CW+1)'(1) >= w_ext) begin
               row_ff <= '0; subr_ff <= '0; tbr_ff <= '0; trow_ff <= '0;
            end else begin
               row_ff <= row_ff + CW'(1);
               if (subr_p1 >= b_eff) begin
                  subr_ff <= '0;
                  tbr_ff  <= tbr_ff + CW'(b_eff);
                  trow_ff <= trow_ff + AW'(1);
               end else begin
                  subr_ff <= subr_ff + pbd_pkg::SUB_W'(1);
               end
            end
         end else begin
            col_ff <= col_ff + CW'(1);
            if (subc_p1 >= b_eff) begin
               subc_ff <= '0;
               tbc_ff  <= tbc_ff + CW'(b_eff);
               tcol_ff <= tcol_ff + AW'(1);
            end else begin
               subc_ff <= subc_ff + pbd_pkg::SUB_W'(1);
            end
         end
      end
   end

   // hold the accepted pixel and its tile flags
   always_ff @(posedge clock) begin
      if (accept) begin
         pr_ff    <= req_tdata[7:0];
         pg_ff    <= req_tdata[15:8];
         pb_ff    <= req_tdata[23:16];
         pa_ff    <= req_tdata[31:24];
         first_ff <= is_first;
         emit_ff  <= is_emit;
         last_ff  <= is_last;
         icol_ff  <= tcol_ff;
         irow_ff  <= trow_ff;
      end
   end

   // accumulate: a tile's first pixel starts from zero
   always_comb begin
      base = first_ff ? '0 : rd_ff;
      upd.red   = base.red   + pbd_pkg::CSUM_W'(16'(pr_ff) * 16'(pa_ff));
      upd.green = base.green + pbd_pkg::CSUM_W'(16'(pg_ff) * 16'(pa_ff));
      upd.blue  = base.blue  + pbd_pkg::CSUM_W'(16'(pb_ff) * 16'(pa_ff));
      upd.alpha = base.alpha + pbd_pkg::ASUM_W'(pa_ff);
   end

   // column sum memory: read every cycle, write back in accumulate
   always_ff @(posedge clock) begin
      rd_ff <= mem[icol_ff];
      if (state_ff == S_ACC) begin
         mem[icol_ff] <= upd;
      end
   end

   always_comb begin
      for (int i = 0; i < LW; i++) begin
         q_clamp[i] = quo_ff[i][QW-1] ? 8'hFF : quo_ff[i][7:0];
      end
      if (zero_ff) begin
         rsp_next[31:0] = '0;
      end else begin
         rsp_next[31:0] = {q_clamp[3], q_clamp[2], q_clamp[1], q_clamp[0]};
      end
      rsp_next[42:32] = pbd_pkg::POS_W'(icol_ff);
      rsp_next[53:43] = pbd_pkg::POS_W'(irow_ff);
      rsp_next[55:54] = '0;
   end

   assign advance = !rsp_valid_ff || rsp_tready;

   // sequencer, divider and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once taken, unless a new one loads in its place
         if (rsp_valid_ff && rsp_tready && state_ff != S_HOLD) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && in_range) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_ACC;
            S_ACC: begin
               // load numerators and pre-shifted divisors
               rem_ff[0] <= NW'({upd.red,   1'b0}) + NW'(upd.alpha);
               rem_ff[1] <= NW'({upd.green, 1'b0}) + NW'(upd.alpha);
               rem_ff[2] <= NW'({upd.blue,  1'b0}) + NW'(upd.alpha);
               rem_ff[3] <= NW'({upd.alpha, 1'b0}) + NW'(area2[9:1]);
               for (int i = 0; i < 3; i++) begin
                  dsh_ff[i] <= SW'({upd.alpha, 1'b0}) << (QW - 1);
               end
               dsh_ff[3] <= SW'(area2) << (QW - 1);
               for (int i = 0; i < LW; i++) begin
                  quo_ff[i] <= '0;
               end
               zero_ff  <= (upd.alpha == '0);
               step_ff  <= '0;
               state_ff <= emit_ff ? S_DIV : S_IDLE;
            end
            S_DIV: begin
               for (int i = 0; i < LW; i++) begin
                  if (rem_ff[i] >= NW'(dsh_ff[i])) begin
                     rem_ff[i] <= rem_ff[i] - NW'(dsh_ff[i]);
                     quo_ff[i] <= {quo_ff[i][QW-2:0], 1'b1};
                  end else begin
                     quo_ff[i] <= {quo_ff[i][QW-2:0], 1'b0};
                  end
                  dsh_ff[i] <= dsh_ff[i] >> 1;
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(QW - 1)) begin
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (advance) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_next;
                  rsp_last_ff  <= last_ff;
                  rsp_zero_ff  <= zero_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a transparent tile gives an all-zero pixel
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_zero_ff) |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero pixel for zero alpha sum");

   // one pixel at a time: no accept in the cycle after an accept into a tile
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (accept && in_range && !csr_we) |=> !req_tready)
      else $error("pixel accepted while another is in flight");

   // result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("pending result overwritten");

endmodule

FILE: tb/sv/premultiplied_box_downscale_checker.sv
// Checker for the box downscaler: predicts each tile pixel and compares it with the result stream.
`timescale 1ns / 1ps
module premultiplied_box_downscale_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pbd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pbd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [pbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              pending_count,
   output int                              result_count
);

   typedef struct packed {
      logic [pbd_pkg::CHAN_W-1:0] red;
      logic [pbd_pkg::CHAN_W-1:0] green;
      logic [pbd_pkg::CHAN_W-1:0] blue;
      logic [pbd_pkg::CHAN_W-1:0] alpha;
      logic [pbd_pkg::POS_W-1:0]  col;
      logic [pbd_pkg::POS_W-1:0]  row;
      logic                       frame_end;
   } tile_pixel_type;

   localparam int MAX_W = 2048;
   localparam int MAX_B = 16;

   logic [pbd_pkg::CSUM_W-1:0] red_acc [MAX_W];
   logic [pbd_pkg::CSUM_W-1:0] green_acc [MAX_W];
   logic [pbd_pkg::CSUM_W-1:0] blue_acc [MAX_W];
   logic [pbd_pkg::ASUM_W-1:0] alpha_acc [MAX_W];
   int unsigned       width_reg, block_reg;
   int unsigned       src_x, src_y, tile_x, tile_y;
   tile_pixel_type    tile_pixels_due[$];

   assign pending_count = tile_pixels_due.size();

   function automatic logic [pbd_pkg::CHAN_W-1:0] weighted_mean(longint unsigned s,
                                                                longint unsigned a);
      longint unsigned q;
      q = (2 * s + a) / (2 * a);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   task automatic restart_frame();
      src_x = 0;
      src_y = 0;
      tile_x = 0;
      tile_y = 0;
   endtask

   // Fold one source pixel into its column sums; queue a tile pixel on the tile's last pixel.
   task automatic accumulate_pixel(input logic [pbd_pkg::REQ_DATA_W-1:0] px);
      int unsigned w, b, tiles, ocol, orow;
      longint unsigned area, am;
      logic [7:0]  r, g, bl, a;
      logic        first;
      tile_pixel_type tp;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
      b = (block_reg == 0) ? 1 : (block_reg > MAX_B) ? MAX_B : block_reg;
      tiles = w / b;
      r = px[7:0];
      g = px[15:8];
      bl = px[23:16];
      a = px[31:24];
      ocol = src_x / b;
      orow = src_y / b;
      if (ocol < tiles && orow < tiles) begin
         first = (tile_x == 0 && tile_y == 0);
         red_acc[ocol]   = (first ? 24'd0 : red_acc[ocol]) + r * a;
         green_acc[ocol] = (first ? 24'd0 : green_acc[ocol]) + g * a;
         blue_acc[ocol]  = (first ? 24'd0 : blue_acc[ocol]) + bl * a;
         alpha_acc[ocol] = (first ? 16'd0 : alpha_acc[ocol]) + a;
         if (tile_x == b - 1 && tile_y == b - 1) begin
            tp = '0;
            if (alpha_acc[ocol] != 0) begin
               tp.red   = weighted_mean(red_acc[ocol], alpha_acc[ocol]);
               tp.green = weighted_mean(green_acc[ocol], alpha_acc[ocol]);
               tp.blue  = weighted_mean(blue_acc[ocol], alpha_acc[ocol]);
               area = b * b;
               am = (2 * alpha_acc[ocol] + area) / (2 * area);
               tp.alpha = (am > 255) ? 8'd255 : am[7:0];
            end
            tp.col = ocol[pbd_pkg::POS_W-1:0];
            tp.row = orow[pbd_pkg::POS_W-1:0];
            tp.frame_end = (ocol == tiles - 1 && orow == tiles - 1);
            tile_pixels_due = {tile_pixels_due, tp};
         end
      end
      // advance the raster position
      if (src_x + 1 >= w) begin
         src_x = 0;
         tile_x = 0;
         if (src_y + 1 >= w) begin
            src_y = 0;
            tile_y = 0;
         end else begin
            src_y++;
            tile_y = (tile_y + 1 >= b) ? 0 : tile_y + 1;
         end
      end else begin
         src_x++;
         tile_x = (tile_x + 1 >= b) ? 0 : tile_x + 1;
      end
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      tile_pixel_type want;
      if (reset) begin
         width_reg = pbd_pkg::SRC_WIDTH_RESET;
         block_reg = pbd_pkg::BLOCK_SIZE_RESET;
         restart_frame();
         tile_pixels_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == pbd_pkg::REG_SRC_WIDTH) width_reg = csr_wdata;
            else if (csr_index == pbd_pkg::REG_BLOCK_SIZE)
               block_reg = csr_wdata[pbd_pkg::BLOCK_W-1:0];
            restart_frame();
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (tile_pixels_due.size() == 0) begin
               report_mismatch("unexpected result beat", 1, 0);
            end else begin
               want = tile_pixels_due.pop_front();
               if (rsp_tdata[7:0] != want.red) report_mismatch("red", rsp_tdata[7:0], want.red);
               if (rsp_tdata[15:8] != want.green)
                  report_mismatch("green", rsp_tdata[15:8], want.green);
               if (rsp_tdata[23:16] != want.blue)
                  report_mismatch("blue", rsp_tdata[23:16], want.blue);
               if (rsp_tdata[31:24] != want.alpha)
                  report_mismatch("alpha", rsp_tdata[31:24], want.alpha);
               if (rsp_tdata[42:32] != want.col) report_mismatch("col", rsp_tdata[42:32], want.col);
               if (rsp_tdata[53:43] != want.row) report_mismatch("row", rsp_tdata[53:43], want.row);
               if (rsp_tlast != want.frame_end)
                  report_mismatch("frame_end", rsp_tlast, want.frame_end);
            end
         end
         if (req_tvalid && req_tready) accumulate_pixel(req_tdata);
      end
   end

endmodule

FILE: tb/sv/premultiplied_box_downscale_tb.sv
// Testbench top for the box downscaler: clock, reset, pixel stimulus and the verdict.
`timescale 1ns / 1ps
module premultiplied_box_downscale_tb;

   localparam int STALL_LIMIT = 4000;   // idle cycles before the watchdog fires
   localparam int DRAIN_WAIT  = 24;     // covers a tile close

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pbd_pkg::REQ_DATA_W-1:0]  req_tdata = '0;   // red, green, blue, alpha
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // red, green, blue, alpha, col, row, zero fill
   logic [pbd_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we = 1'b0;
   logic [pbd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pbd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int error_count, pending_count, result_count;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int pixels_sent = 0;
   int phase_count = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   premultiplied_box_downscale u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   premultiplied_box_downscale_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pending_count), .result_count(result_count)
   );

   // Stall the result side at the current rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: count cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offer one pixel; hold it until the beat is taken. Valid stays high for
   // back-to-back pixels, so it is only lowered when a gap is inserted.
   task automatic send_pixel(input logic [7:0] r, g, b, a);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {a, b, g, r};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      pixels_sent++;
   endtask

   task automatic random_pixel();
      logic [7:0] a;
      case ($urandom_range(5))
         0: a = 8'd0;
         1: a = 8'd255;
         default: a = 8'($urandom_range(255));
      endcase
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), a);
   endtask

   // Drop valid, wait until every tile pixel has come back, then let the divider settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pbd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pbd_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Start a new phase: drain, program both registers, pick the idling mix.
   task automatic new_phase(input int w, input int b);
      drain();
      write_reg(pbd_pkg::REG_SRC_WIDTH, pbd_pkg::CSR_DATA_W'(w));
      write_reg(pbd_pkg::REG_BLOCK_SIZE, pbd_pkg::CSR_DATA_W'(b));
      case (phase_count % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
         default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      phase_count++;
   endtask

   initial begin
      int w, b, n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings (width 128, block 2): the top row of the top left tile, then drop it.
      send_pixel(8'd255, 8'd0, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0, 8'd255);

      // Two-by-two tiles: transparent tile, opaque extremes, mixed alpha.
      new_phase(4, 2);
      repeat (2) send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd255, 8'd255);
      repeat (2) send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd1);
      repeat (8) random_pixel();

      // Single pixel image; width zero acts as one.
      new_phase(1, 1);
      send_pixel(8'd128, 8'd64, 8'd32, 8'd3);
      new_phase(0, 1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255);

      // Width not a multiple of the block, and width below the block size.
      new_phase(7, 3);
      repeat (49) random_pixel();
      new_phase(2, 3);
      repeat (4) random_pixel();

      // Block zero acts as one; block above the maximum acts as sixteen.
      new_phase(5, 0);
      repeat (25) random_pixel();
      new_phase(16, 31);
      repeat (256) send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
      new_phase(16, 16);
      repeat (256) random_pixel();

      // Width above the maximum clamps to the largest image; take the first row only.
      new_phase(4095, 1);
      repeat (40) random_pixel();

      // Random phases: small frames, mostly whole frames, sometimes cut short.
      while (pixels_sent < 1350) begin
         w = $urandom_range(1, 12);
         case ($urandom_range(9))
            0: b = 0;
            1: b = $urandom_range(5, 16);
            2: b = $urandom_range(17, 31);
            default: b = $urandom_range(1, 4);
         endcase
         new_phase(w, b);
         n = w * w * $urandom_range(1, 2);
         if ($urandom_range(5) == 0) n = $urandom_range(1, n);
         repeat (n) random_pixel();
      end

      drain();
      $display("Covered %0d pixels over %0d register settings, %0d tile pixels returned",
               pixels_sent, phase_count, result_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
